// File: design/tcq_pkg.sv
package tcq_pkg;

    // Operation codes carried in the kind field
    typedef enum logic [1:0] {
        KIND_INSERT     = 2'd0,
        KIND_SERVE_PREF = 2'd1,
        KIND_SERVE_GEN  = 2'd2,
        KIND_WITHDRAW   = 2'd3
    } t_kind;

    // Which cell a removal picks
    typedef enum logic [1:0] {
        SRC_HEAD  = 2'd0,
        SRC_PREF  = 2'd1,
        SRC_MATCH = 2'd2
    } t_src;

    // Width of the count fields in a result item
    localparam int unsigned COUNT_OUT_W = 5;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic capture;   // item accepted: latch compare results
        logic do_remove; // apply: remove the selected cell and compact
        t_src src;       // apply: selection rule for the removal
        logic do_insert; // apply: append at the first free cell
    } t_cell_ctrl;

endpackage

// File: design/tcq_if.sv
// Input channel: one operation per item
interface tcq_in_if #(
    parameter int ID_WIDTH = 16
);
    import tcq_pkg::*;
    logic                       valid;
    logic                       ready;
    t_kind                      kind;
    logic signed [ID_WIDTH-1:0] id;
    logic                       is_preferential;

    modport source (output valid, kind, id, is_preferential, input ready);
    modport sink   (input valid, kind, id, is_preferential, output ready);
endinterface

// Output channel: one result per operation
interface tcq_out_if #(
    parameter int ID_WIDTH = 16
);
    import tcq_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   ok;
    logic [ID_WIDTH-2:0]    served_id;
    logic [COUNT_OUT_W-1:0] total_count;
    logic [COUNT_OUT_W-1:0] preferential_count;

    modport source (output valid, ok, served_id, total_count, preferential_count,
                    input ready);
    modport sink   (input valid, ok, served_id, total_count, preferential_count,
                    output ready);
endinterface

// File: design/tcq_cell.sv
module tcq_cell
    import tcq_pkg::*;
#(
    parameter int PID_W = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctrl       i_ctrl,
    input  logic [PID_W-1:0] i_id,        // compare id at capture, new id at apply
    input  logic             i_flag,      // new flag at apply
    input  logic             i_head,      // high on the oldest position only
    // from the older neighbor
    input  logic             i_left_occ,
    input  logic             i_pref_seen,
    input  logic             i_match_seen,
    input  logic             i_shift,
    input  logic [PID_W-1:0] i_srv_id,
    input  logic             i_srv_flag,
    // from the younger neighbor
    input  logic             i_right_occ,
    input  logic [PID_W-1:0] i_right_id,
    input  logic             i_right_flag,
    // to the neighbors
    output logic             o_occ,
    output logic [PID_W-1:0] o_id,
    output logic             o_flag,
    output logic             o_pref_seen,
    output logic             o_match_seen,
    output logic             o_shift,
    output logic [PID_W-1:0] o_srv_id,
    output logic             o_srv_flag
);

    logic             r_occ;
    logic [PID_W-1:0] r_id;
    logic             r_flag;
    logic             r_match;
    logic             r_first_pref;

    logic             hit;
    logic             pref_here;
    logic             sel;
    logic             shift;

    // Compare and flag scan, used at capture
    assign hit       = r_occ && (r_id == i_id);
    assign pref_here = r_occ && r_flag;

    assign o_pref_seen  = i_pref_seen | pref_here;
    assign o_match_seen = i_match_seen | hit;

    // Removal select and compaction
    always_comb begin
        case (i_ctrl.src)
            SRC_HEAD:  sel = i_head;
            SRC_PREF:  sel = r_first_pref;
            SRC_MATCH: sel = r_match;
            default:   sel = 1'b0;
        endcase
        sel   = sel & i_ctrl.do_remove;
        shift = i_shift | sel;
    end

    assign o_shift    = shift;
    assign o_srv_id   = i_srv_id | (sel ? r_id : '0);
    assign o_srv_flag = i_srv_flag | (sel & r_flag);

    assign o_occ  = r_occ;
    assign o_id   = r_id;
    assign o_flag = r_flag;

    // Occupancy (control)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (shift) begin
            r_occ <= i_right_occ;
        end else if (i_ctrl.do_insert && !r_occ && i_left_occ) begin
            r_occ <= 1'b1;
        end
    end

    // Entry payload
    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_id   <= i_right_id;
            r_flag <= i_right_flag;
        end else if (i_ctrl.do_insert && !r_occ && i_left_occ) begin
            r_id   <= i_id;
            r_flag <= i_flag;
        end
    end

    // Capture compare results for the apply cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_match      <= hit;
            r_first_pref <= pref_here && !i_pref_seen;
        end
    end

endmodule

// File: design/two_class_queue_with_cancel.sv
// Two-class waiting queue with withdrawal. Entries sit in a row of cells in
// arrival order; each cell holds an id and a preferential flag. Operations:
// insert (rejects a negative id, a duplicate or a full row), serve the oldest
// preferential entry (the oldest entry when none is flagged), serve the oldest
// entry, and withdraw a given id. Each item yields one result with ok, the
// served id and both counts. At acceptance every cell compares its id and
// scans its flag, and in the next cycle an insert is appended at the first
// free cell or the selected cell is removed while the cells behind it shift
// forward one place. The result is written to the output register as the
// apply cycle ends; from then on the next item is taken when the result is
// being taken or the output register is empty, and no item is taken while
// another is being applied. No clearing after reset is needed.
module two_class_queue_with_cancel
    import tcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcq_in_if.sink      i_in,
    tcq_out_if.source   o_out
);

    localparam int PID_W   = ID_WIDTH - 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_APPLY = 2'b10
    } t_state;

    t_state              r_state;
    t_kind               r_kind;
    logic [PID_W-1:0]    r_op_id;
    logic                r_op_neg;
    logic                r_op_flag;
    logic                r_any_pref;
    logic                r_any_match;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  r_pref_count;
    logic [COUNT_W-1:0]  n_count;
    logic [COUNT_W-1:0]  n_pref_count;

    logic                r_out_valid;
    logic                r_out_ok;
    logic [PID_W-1:0]    r_out_served;
    logic [COUNT_W-1:0]  r_out_total;
    logic [COUNT_W-1:0]  r_out_pref;

    logic                accept;
    logic                op_ok;
    logic                is_serve;
    t_cell_ctrl          ctrl;
    logic [PID_W-1:0]    bcast_id;
    logic                bcast_flag;

    // Neighbor chains
    logic             cell_occ  [QUEUE_DEPTH];
    logic [PID_W-1:0] cell_id   [QUEUE_DEPTH];
    logic             cell_flag [QUEUE_DEPTH];
    logic             ch_left_occ   [QUEUE_DEPTH+1];
    logic             ch_pref_seen  [QUEUE_DEPTH+1];
    logic             ch_match_seen [QUEUE_DEPTH+1];
    logic             ch_shift      [QUEUE_DEPTH+1];
    logic [PID_W-1:0] ch_srv_id     [QUEUE_DEPTH+1];
    logic             ch_srv_flag   [QUEUE_DEPTH+1];

    // Input handshake
    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    // Payload broadcast: live input at capture, latched item at apply
    assign bcast_id   = (r_state == ST_APPLY) ? r_op_id : i_in.id[PID_W-1:0];
    assign bcast_flag = r_op_flag;

    // Decision for the apply cycle
    always_comb begin
        ctrl         = '0;
        ctrl.capture = accept;
        ctrl.src     = SRC_HEAD;
        op_ok        = 1'b0;
        is_serve     = 1'b0;
        case (r_kind)
            KIND_INSERT: begin
                op_ok = !r_op_neg && !r_any_match &&
                        (r_count < COUNT_W'(QUEUE_DEPTH));
                ctrl.do_insert = op_ok && (r_state == ST_APPLY);
            end
            KIND_SERVE_PREF, KIND_SERVE_GEN: begin
                is_serve = 1'b1;
                op_ok    = (r_count != '0);
                if (r_kind == KIND_SERVE_PREF && r_any_pref) begin
                    ctrl.src = SRC_PREF;
                end
                ctrl.do_remove = op_ok && (r_state == ST_APPLY);
            end
            KIND_WITHDRAW: begin
                op_ok          = !r_op_neg && r_any_match;
                ctrl.src       = SRC_MATCH;
                ctrl.do_remove = op_ok && (r_state == ST_APPLY);
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
    end

    // Count updates
    always_comb begin
        n_count      = r_count;
        n_pref_count = r_pref_count;
        if (ctrl.do_insert) begin
            n_count      = r_count + COUNT_W'(1);
            n_pref_count = r_pref_count + COUNT_W'(r_op_flag);
        end else if (ctrl.do_remove) begin
            n_count      = r_count - COUNT_W'(1);
            n_pref_count = r_pref_count - COUNT_W'(ch_srv_flag[QUEUE_DEPTH]);
        end
    end

    // Chain ends
    assign ch_left_occ[0]   = 1'b1;
    assign ch_pref_seen[0]  = 1'b0;
    assign ch_match_seen[0] = 1'b0;
    assign ch_shift[0]      = 1'b0;
    assign ch_srv_id[0]     = '0;
    assign ch_srv_flag[0]   = 1'b0;

    // Row of cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic             right_occ;
        logic [PID_W-1:0] right_id;
        logic             right_flag;

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_occ  = 1'b0;
            assign right_id   = '0;
            assign right_flag = 1'b0;
        end else begin : g_mid
            assign right_occ  = cell_occ[g+1];
            assign right_id   = cell_id[g+1];
            assign right_flag = cell_flag[g+1];
        end

        assign ch_left_occ[g+1] = cell_occ[g];

        tcq_cell #(
            .PID_W (PID_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_id         (bcast_id),
            .i_flag       (bcast_flag),
            .i_head       (g == 0),
            .i_left_occ   (ch_left_occ[g]),
            .i_pref_seen  (ch_pref_seen[g]),
            .i_match_seen (ch_match_seen[g]),
            .i_shift      (ch_shift[g]),
            .i_srv_id     (ch_srv_id[g]),
            .i_srv_flag   (ch_srv_flag[g]),
            .i_right_occ  (right_occ),
            .i_right_id   (right_id),
            .i_right_flag (right_flag),
            .o_occ        (cell_occ[g]),
            .o_id         (cell_id[g]),
            .o_flag       (cell_flag[g]),
            .o_pref_seen  (ch_pref_seen[g+1]),
            .o_match_seen (ch_match_seen[g+1]),
            .o_shift      (ch_shift[g+1]),
            .o_srv_id     (ch_srv_id[g+1]),
            .o_srv_flag   (ch_srv_flag[g+1])
        );
    end

    // Sequencer and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_pref_count <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    r_state      <= ST_IDLE;
                    r_count      <= n_count;
                    r_pref_count <= n_pref_count;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Latched item and scan results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind      <= i_in.kind;
            r_op_id     <= i_in.id[PID_W-1:0];
            r_op_neg    <= i_in.id[ID_WIDTH-1];
            r_op_flag   <= i_in.is_preferential;
            r_any_pref  <= ch_pref_seen[QUEUE_DEPTH];
            r_any_match <= ch_match_seen[QUEUE_DEPTH];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_APPLY) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_APPLY) begin
            r_out_ok     <= op_ok;
            r_out_served <= (is_serve && op_ok) ? ch_srv_id[QUEUE_DEPTH] : '0;
            r_out_total  <= n_count;
            r_out_pref   <= n_pref_count;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.ok                 = r_out_ok;
    assign o_out.served_id          = r_out_served;
    assign o_out.total_count        = COUNT_OUT_W'(r_out_total);
    assign o_out.preferential_count = COUNT_OUT_W'(r_out_pref);

endmodule
